@@ hdl/rvoi_pkg.sv @@
// shared types and constants for the op-imm execute block
`default_nettype none
package rvoi_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = 5;

  // funct3 codes of the op-imm group
  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_SLLI  = 3'd1;
  localparam logic [2:0] F3_SLTI  = 3'd2;
  localparam logic [2:0] F3_SLTIU = 3'd3;
  localparam logic [2:0] F3_XORI  = 3'd4;
  localparam logic [2:0] F3_SRXI  = 3'd5;
  localparam logic [2:0] F3_ORI   = 3'd6;
  localparam logic [2:0] F3_ANDI  = 3'd7;

  // register file write port
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rvoi_wr_t;

endpackage
`default_nettype wire

@@ hdl/rvoi_if.sv @@
// valid/ready channel interfaces for instructions and write results
`default_nettype none
interface rvoi_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvoi_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_index;
  logic [31:0] write_value;
  logic        write_done;

  modport source (output valid, output dest_index, output write_value, output write_done,
                  input ready);
  modport sink   (input valid, input dest_index, input write_value, input write_done,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/rvoi_regfile.sv @@
// 32 x 32 register file memory with registered read and per-entry valid bits
`default_nettype none
module rvoi_regfile
  import rvoi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [REG_AW-1:0] rd_addr,
  output logic [XLEN-1:0]        rd_data,
  input  wire rvoi_wr_t          wr
);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [XLEN-1:0]      mem_q;
  logic                 valid_q;

  // memory write and synchronous read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule
`default_nettype wire

@@ hdl/rvoi_alu.sv @@
// immediate decode and alu for the op-imm group
`default_nettype none
module rvoi_alu
  import rvoi_pkg::*;
(
  input  wire logic [31:0]     word,
  input  wire logic [XLEN-1:0] operand,
  output logic [XLEN-1:0]      result
);

  logic [XLEN-1:0] imm;
  logic [4:0]      shamt;
  logic            arith;

  // field decode
  assign imm   = {{(XLEN-12){word[31]}}, word[31:20]};
  assign shamt = word[24:20];
  assign arith = word[30];

  // operation select
  always_comb begin
    case (word[14:12])
      F3_ADDI:  result = operand + imm;
      F3_SLLI:  result = operand << shamt;
      F3_SLTI:  result = {{(XLEN-1){1'b0}}, ($signed(operand) < $signed(imm))};
      F3_SLTIU: result = {{(XLEN-1){1'b0}}, (operand < imm)};
      F3_XORI:  result = operand ^ imm;
      F3_SRXI:  result = arith ? XLEN'($signed(operand) >>> shamt) : (operand >> shamt);
      F3_ORI:   result = operand | imm;
      F3_ANDI:  result = operand & imm;
      default:  result = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/rv32i_op_imm_execute_core.sv @@
// RV32I op-imm execute block: top level
//
// The req channel takes one 32-bit op-imm instruction word per item. The rsp
// channel returns one item per instruction: rd, the value written and a flag
// that is low when rd is x0 (value then reads zero, nothing is written).
// Both channels move an item when valid and ready are high at a clock edge.
//
// An accepted item goes through the read stage and the output register to rsp.
// One instruction is accepted per cycle while req.ready is high; the rs1 read
// in the register file memory happens at acceptance, the alu and the write
// back when the item moves into the output register. A write on the same edge
// as the next item's read of that register is forwarded around the memory.
//
// Synchronous reset clears all pipeline valids and the per-register valid
// bits, so every register reads zero afterwards; no clearing sweep is needed.
// When the receiver holds rsp.ready low, the output register keeps its item,
// one more item waits in the read stage and req.ready drops.
`default_nettype none
module rv32i_op_imm_execute_core
  import rvoi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  rvoi_req_if.sink   req,
  rvoi_rsp_if.source rsp
);

  logic            out_free;
  logic            s1_adv;
  logic            accept;
  logic            s1_valid;
  logic            s1_valid_next;
  logic [31:0]     s1_word;
  logic            fwd_hit;
  logic [XLEN-1:0] fwd_val;
  logic [XLEN-1:0] rf_data;
  logic [XLEN-1:0] operand;
  logic [XLEN-1:0] result;
  logic [4:0]      s1_rd;
  rvoi_wr_t        wr;

  // handshake control
  assign out_free      = !rsp.valid || rsp.ready;
  assign s1_adv        = s1_valid && out_free;
  assign req.ready     = !s1_valid || out_free;
  assign accept        = req.valid && req.ready;
  assign s1_valid_next = accept || (s1_valid && !s1_adv);
  assign s1_rd         = s1_word[11:7];

  // register file memory, rs1 read at acceptance
  rvoi_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (req.instruction_word[19:15]),
    .rd_data (rf_data),
    .wr      (wr)
  );

  // operand with bypass of a same-edge write
  assign operand = fwd_hit ? fwd_val : rf_data;

  rvoi_alu u_alu (
    .word    (s1_word),
    .operand (operand),
    .result  (result)
  );

  // write back as the item leaves the read stage; x0 never written
  assign wr.en   = s1_adv && (s1_rd != '0);
  assign wr.addr = s1_rd;
  assign wr.data = result;

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // read stage payload and forwarding capture
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= req.instruction_word;
      fwd_hit <= wr.en && (wr.addr == req.instruction_word[19:15]);
      fwd_val <= wr.data;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.dest_index  <= s1_rd;
      rsp.write_value <= wr.en ? result : '0;
      rsp.write_done  <= wr.en;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rvoi_checker.sv @@
// port-level checks for the op-imm execute block and their bind
`default_nettype none
module rvoi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [4:0]  rsp_dest_index,
  input wire logic [31:0] rsp_write_value,
  input wire logic        rsp_write_done
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp item dropped while stalled");

  // write flag follows the destination register
  a_done_rd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_write_done == (rsp_dest_index != 5'd0)))
    else $error("write flag does not match destination");

  // x0 results carry zero
  a_x0_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_write_done |-> rsp_write_value == 32'd0)
    else $error("x0 result not zero");

  // nothing offered right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

endmodule

bind rv32i_op_imm_execute_core rvoi_checker u_rvoi_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_dest_index  (rsp.dest_index),
  .rsp_write_value (rsp.write_value),
  .rsp_write_done  (rsp.write_done)
);
`default_nettype wire
